// ===== sv/fus_pkg.sv =====
// ----------------------------------------------------------------------------
// fus_pkg
// Shared sizes, types and count codes for the first unique symbol stream.
// ----------------------------------------------------------------------------
package fus_pkg;

	localparam int ALPHABET_SIZE = 26;
	localparam int SYM_W         = 5;
	localparam int IDX_W         = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
	localparam int FILL_W        = $clog2(ALPHABET_SIZE + 1);

	typedef logic [1:0]        cnt_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [FILL_W-1:0] fill_t;

	// saturating occurrence count codes
	localparam cnt_t CNT_NONE = 2'd0;
	localparam cnt_t CNT_ONCE = 2'd1;
	localparam cnt_t CNT_MANY = 2'd2;

endpackage

// ===== sv/first_unique_symbol_stream.sv =====
// ----------------------------------------------------------------------------
// first_unique_symbol_stream
// Reports, after every symbol beat, the earliest symbol of the current stream
// that has so far appeared exactly once.
// ----------------------------------------------------------------------------
// Usage
//   Symbol channel: sym_valid / sym_stall carry restart and symbol. A beat is
//   taken at a rising edge with sym_valid high and sym_stall low. restart set
//   on a beat clears all counts and the order queue before that symbol counts.
//   Result channel: res_valid / res_stall carry found and first_unique; found
//   low means no once-seen symbol exists and first_unique then reads zero.
//   Timing: one beat at a time. From the symbol beat the sequencer runs the
//   count update, then head checks until the order queue is empty or its
//   head is once-seen, then the hand-over; a symbol out of range skips the
//   count update. Each head check is one order-queue read, one count read
//   and one compare, both memories single-port synchronous. Each symbol is
//   popped at most once per stream. The next symbol beat is taken at the
//   earliest in the cycle after the result loads.
//   Reset (arst_n low) clears the count valid bits, head, tail and fill at
//   once; no clearing pass is needed. The order queue is not cleared.
//   A stalled result holds in the output register; the next symbol beat is
//   still taken and worked, and waits only at its final hand-over.
// ----------------------------------------------------------------------------
module first_unique_symbol_stream
	import fus_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sym_valid,
	output logic             sym_stall,
	input  logic             restart,
	input  logic [SYM_W-1:0] symbol,
	output logic             res_valid,
	input  logic             res_stall,
	output logic             found,
	output logic [SYM_W-1:0] first_unique
);

	// sequencer codes
	localparam logic [2:0] S_IDLE = 3'd0; // wait for a symbol beat
	localparam logic [2:0] S_UPD  = 3'd1; // count read back: write count, push
	localparam logic [2:0] S_QRD  = 3'd2; // read order queue at head
	localparam logic [2:0] S_CRD  = 3'd3; // read count of the head symbol
	localparam logic [2:0] S_CHK  = 3'd4; // pop a repeated head or finish
	localparam logic [2:0] S_OUT  = 3'd5; // hand result to the output register

	// Memories: counts and arrival order, one synchronous port each
	cnt_t count_mem [ALPHABET_SIZE];
	idx_t queue_mem [ALPHABET_SIZE];

	// Flip-flop valid bits stand for the count reset: an entry not valid is zero
	logic [ALPHABET_SIZE-1:0] count_valid_q;

	logic [2:0] state_q;
	idx_t       head_q;
	idx_t       tail_q;
	fill_t      fill_q;

	cnt_t       count_rd_q;
	idx_t       queue_rd_q;
	idx_t       sym_idx_s1;
	logic       in_range_s1;

	logic             pend_found_q;
	logic [SYM_W-1:0] pend_sym_q;

	logic             res_valid_q;
	logic             found_q;
	logic [SYM_W-1:0] first_unique_q;

	logic       sym_take;
	logic       sym_in_range;
	idx_t       sym_idx;
	idx_t       count_raddr;
	logic       count_re;
	cnt_t       upd_count;
	cnt_t       chk_count;
	logic       push;
	logic       res_free;

	assign sym_stall    = (state_q != S_IDLE);
	assign sym_take     = sym_valid && (state_q == S_IDLE);
	assign sym_in_range = (symbol < SYM_W'(ALPHABET_SIZE));
	assign sym_idx      = sym_in_range ? IDX_W'(symbol) : '0;

	// Count as seen after this beat's restart: valid bits are already cleared
	assign upd_count = count_valid_q[sym_idx_s1] ? count_rd_q : CNT_NONE;
	assign chk_count = count_valid_q[queue_rd_q] ? count_rd_q : CNT_NONE;
	assign push      = (state_q == S_UPD) && in_range_s1 && (upd_count == CNT_NONE)
	                   && (fill_q < FILL_W'(ALPHABET_SIZE));

	assign count_re    = sym_take || (state_q == S_CRD);
	assign count_raddr = (state_q == S_CRD) ? queue_rd_q : sym_idx;

	assign res_free = !res_valid_q || !res_stall;

	// Count memory: registered read in the cycle before its use, write back in the update step
	always_ff @(posedge clk) begin
		if (count_re) begin
			count_rd_q <= count_mem[count_raddr];
		end
		if ((state_q == S_UPD) && in_range_s1) begin
			count_mem[sym_idx_s1] <= (upd_count == CNT_NONE) ? CNT_ONCE : CNT_MANY;
		end
	end

	// Order queue memory
	always_ff @(posedge clk) begin
		if (state_q == S_QRD) begin
			queue_rd_q <= queue_mem[head_q];
		end
		if (push) begin
			queue_mem[tail_q] <= sym_idx_s1;
		end
	end

	// Beat capture
	always_ff @(posedge clk) begin
		if (sym_take) begin
			sym_idx_s1  <= sym_idx;
			in_range_s1 <= sym_in_range;
		end
	end

	// Sequencer, queue pointers and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			count_valid_q <= '0;
			head_q        <= '0;
			tail_q        <= '0;
			fill_q        <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (sym_take) begin
						// restart drops the whole stream before this symbol
						if (restart) begin
							count_valid_q <= '0;
							head_q        <= '0;
							tail_q        <= '0;
							fill_q        <= '0;
						end
						state_q <= sym_in_range ? S_UPD : S_QRD;
					end
				end
				S_UPD: begin
					if (in_range_s1) begin
						count_valid_q[sym_idx_s1] <= 1'b1;
					end
					if (push) begin
						tail_q <= (tail_q == IDX_W'(ALPHABET_SIZE - 1)) ? '0 : tail_q + 1'b1;
						fill_q <= fill_q + 1'b1;
					end
					state_q <= S_QRD;
				end
				S_QRD: begin
					state_q <= (fill_q == '0) ? S_OUT : S_CRD;
				end
				S_CRD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (chk_count == CNT_MANY) begin
						// head repeated: advance and look again
						head_q  <= (head_q == IDX_W'(ALPHABET_SIZE - 1)) ? '0 : head_q + 1'b1;
						fill_q  <= fill_q - 1'b1;
						state_q <= S_QRD;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Pending result, settled before the hand-over
	always_ff @(posedge clk) begin
		if ((state_q == S_QRD) && (fill_q == '0)) begin
			pend_found_q <= 1'b0;
			pend_sym_q   <= '0;
		end else if ((state_q == S_CHK) && (chk_count != CNT_MANY)) begin
			pend_found_q <= 1'b1;
			pend_sym_q   <= SYM_W'(queue_rd_q);
		end
	end

	// Output register: load only when empty or being taken, else hold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if ((state_q == S_OUT) && res_free) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_OUT) && res_free) begin
			found_q        <= pend_found_q;
			first_unique_q <= pend_sym_q;
		end
	end

	assign res_valid    = res_valid_q;
	assign found        = found_q;
	assign first_unique = first_unique_q;

endmodule
